// ===== rtl/llp_pkg.sv =====
`timescale 1ns / 1ps
package llp_pkg;

	localparam int STEP_W = 4;

	// step numbers of the microprogram
	localparam logic [STEP_W-1:0] ST_IDLE       = 4'd0;
	localparam logic [STEP_W-1:0] ST_WALK_VISIT = 4'd1;
	localparam logic [STEP_W-1:0] ST_WALK_LINK  = 4'd2;
	localparam logic [STEP_W-1:0] ST_SCAN_INIT  = 4'd3;
	localparam logic [STEP_W-1:0] ST_SCAN_FETCH = 4'd4;
	localparam logic [STEP_W-1:0] ST_SCAN_ADDR  = 4'd5;
	localparam logic [STEP_W-1:0] ST_SCAN_CHECK = 4'd6;
	localparam logic [STEP_W-1:0] ST_NEXT_CLASS = 4'd7;
	localparam logic [STEP_W-1:0] ST_FLUSH      = 4'd8;

	localparam int VALUE_W = 32;
	localparam int LINK_W  = 7;
	localparam int ADDR_W  = 6;
	localparam int THR_W   = 31;
	localparam logic [LINK_W-1:0] LINK_NULL = 7'h7F;

	localparam logic [1:0] CLS_NEG  = 2'd0;
	localparam logic [1:0] CLS_MID  = 2'd1;
	localparam logic [1:0] CLS_HIGH = 2'd2;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_RUN,
		COND_WALK_DONE,
		COND_SCAN_DONE,
		COND_MORE_CLASS
	} cond_t;

	typedef struct packed {
		logic accept;      // idle step, takes commands
		logic walk_visit;  // record cur in visit list, read node at cur
		logic ld_link;     // cur <= link of node just read
		logic scan_clr;    // class and scan index to zero
		logic node_rd_vis; // read node at visit entry, bump scan index
		logic check;       // classify node, emit pending result on match
		logic cls_inc;     // step to next class
		logic flush;       // emit final pending result
	} ctrl_t;

	typedef struct packed {
		logic run_start;
		logic walk_done;
		logic scan_done;
		logic last_class;
	} status_t;

	typedef struct packed {
		cond_t             cond;
		logic [STEP_W-1:0] target;
		logic              gate;   // enables act only when jump not taken
		ctrl_t             ctrl;
	} uword_t;

	function automatic uword_t ucode(input logic [STEP_W-1:0] step);
		uword_t w;
		w = '0;
		w.cond = COND_ALWAYS;
		w.target = ST_IDLE;
		unique case (step)
			ST_IDLE: begin
				w.cond = COND_NO_RUN;
				w.target = ST_IDLE;
				w.ctrl.accept = 1'b1;
			end
			ST_WALK_VISIT: begin
				w.cond = COND_WALK_DONE;
				w.target = ST_SCAN_INIT;
				w.gate = 1'b1;
				w.ctrl.walk_visit = 1'b1;
			end
			ST_WALK_LINK: begin
				w.cond = COND_ALWAYS;
				w.target = ST_WALK_VISIT;
				w.ctrl.ld_link = 1'b1;
			end
			ST_SCAN_INIT: begin
				w.cond = COND_NEVER;
				w.ctrl.scan_clr = 1'b1;
			end
			ST_SCAN_FETCH: begin
				w.cond = COND_SCAN_DONE;
				w.target = ST_NEXT_CLASS;
			end
			ST_SCAN_ADDR: begin
				w.cond = COND_NEVER;
				w.ctrl.node_rd_vis = 1'b1;
			end
			ST_SCAN_CHECK: begin
				w.cond = COND_ALWAYS;
				w.target = ST_SCAN_FETCH;
				w.ctrl.check = 1'b1;
			end
			ST_NEXT_CLASS: begin
				w.cond = COND_MORE_CLASS;
				w.target = ST_SCAN_FETCH;
				w.ctrl.cls_inc = 1'b1;
			end
			ST_FLUSH: begin
				w.cond = COND_ALWAYS;
				w.target = ST_IDLE;
				w.ctrl.flush = 1'b1;
			end
			default: begin
				w.cond = COND_ALWAYS;
				w.target = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/llp_ram.sv =====
`timescale 1ns / 1ps
module llp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/llp_seq.sv =====
`timescale 1ns / 1ps
module llp_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  llp_pkg::status_t status,
	output llp_pkg::ctrl_t   ctrl
);

	logic [llp_pkg::STEP_W-1:0] step_q;
	logic [llp_pkg::STEP_W-1:0] step_next;
	llp_pkg::uword_t            word;
	logic                       taken;

	assign word = llp_pkg::ucode(step_q);

	always_comb begin
		unique case (word.cond)
			llp_pkg::COND_NEVER:      taken = 1'b0;
			llp_pkg::COND_ALWAYS:     taken = 1'b1;
			llp_pkg::COND_NO_RUN:     taken = !status.run_start;
			llp_pkg::COND_WALK_DONE:  taken = status.walk_done;
			llp_pkg::COND_SCAN_DONE:  taken = status.scan_done;
			llp_pkg::COND_MORE_CLASS: taken = !status.last_class;
			default:                  taken = 1'b1;
		endcase
		step_next = taken ? word.target : step_q + 1'b1;
		ctrl = word.ctrl;
		if (word.gate && taken) begin
			ctrl = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= llp_pkg::ST_IDLE;
		end else begin
			step_q <= step_next;
		end
	end

endmodule

// ===== rtl/llp_dp.sv =====
`timescale 1ns / 1ps
module llp_dp #(
	parameter int NODE_COUNT = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  llp_pkg::ctrl_t        ctrl,
	output llp_pkg::status_t      status,
	input  logic                  start,
	input  logic                  req_type,
	input  logic signed [6:0]     node_addr,
	input  logic signed [31:0]    node_value,
	input  logic signed [6:0]     link_addr,
	input  logic                  cfg_valid,
	input  logic [30:0]           cfg_data,
	output logic                  out_strobe,
	output logic [5:0]            out_addr,
	output logic signed [31:0]    out_value,
	output logic signed [6:0]     out_link,
	output logic                  last
);

	localparam int AW = $clog2(NODE_COUNT);
	localparam int CW = $clog2(NODE_COUNT + 1);
	localparam int NW = llp_pkg::LINK_W + llp_pkg::VALUE_W;

	logic [llp_pkg::THR_W-1:0]   threshold_q;
	logic [llp_pkg::LINK_W-1:0]  cur_q;
	logic [CW-1:0]               n_q;
	logic [CW-1:0]               i_q;
	logic [1:0]                  cls_q;
	logic [AW-1:0]               a_q;
	logic                        pend_q;
	logic [AW-1:0]               pend_addr_q;
	logic [llp_pkg::VALUE_W-1:0] pend_value_q;

	logic                        strobe_q;
	logic [llp_pkg::ADDR_W-1:0]  out_addr_q;
	logic [llp_pkg::VALUE_W-1:0] out_value_q;
	logic [llp_pkg::LINK_W-1:0]  out_link_q;
	logic                        last_q;

	logic                        load_we;
	logic                        run_start;
	logic                        cur_ok;
	logic [AW-1:0]               node_raddr;
	logic [NW-1:0]               node_rd;
	logic [AW-1:0]               vis_rd;
	logic [llp_pkg::VALUE_W-1:0] rd_value;
	logic [1:0]                  rd_cls;
	logic                        hit;

	assign load_we = ctrl.accept && start && !req_type && !node_addr[6]
		&& ($unsigned(node_addr) < 7'(NODE_COUNT));
	assign run_start = ctrl.accept && start && req_type;
	assign cur_ok = !cur_q[6] && (cur_q < 7'(NODE_COUNT));

	assign status.run_start  = run_start;
	assign status.walk_done  = !cur_ok || (n_q == CW'(NODE_COUNT));
	assign status.scan_done  = (i_q == n_q);
	assign status.last_class = (cls_q == llp_pkg::CLS_HIGH);

	// node table: link over value
	assign node_raddr = ctrl.node_rd_vis ? vis_rd : cur_q[AW-1:0];

	llp_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_node_ram (
		.clk   (clk),
		.we    (load_we),
		.waddr (node_addr[AW-1:0]),
		.wdata ({link_addr, node_value}),
		.raddr (node_raddr),
		.rdata (node_rd)
	);

	llp_ram #(.WIDTH(AW), .DEPTH(NODE_COUNT)) u_visit_ram (
		.clk   (clk),
		.we    (ctrl.walk_visit),
		.waddr (n_q[AW-1:0]),
		.wdata (cur_q[AW-1:0]),
		.raddr (i_q[AW-1:0]),
		.rdata (vis_rd)
	);

	assign rd_value = node_rd[llp_pkg::VALUE_W-1:0];

	always_comb begin
		priority if (rd_value[31]) begin
			rd_cls = llp_pkg::CLS_NEG;
		end else if (rd_value[30:0] <= threshold_q) begin
			rd_cls = llp_pkg::CLS_MID;
		end else begin
			rd_cls = llp_pkg::CLS_HIGH;
		end
	end

	assign hit = ctrl.check && (rd_cls == cls_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
			n_q <= '0;
			i_q <= '0;
			cls_q <= llp_pkg::CLS_NEG;
			pend_q <= 1'b0;
			strobe_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				threshold_q <= cfg_data;
			end
			if (run_start) begin
				n_q <= '0;
				pend_q <= 1'b0;
			end
			if (ctrl.walk_visit) begin
				n_q <= n_q + 1'b1;
			end
			if (ctrl.scan_clr) begin
				i_q <= '0;
				cls_q <= llp_pkg::CLS_NEG;
			end
			if (ctrl.node_rd_vis) begin
				i_q <= i_q + 1'b1;
			end
			if (ctrl.cls_inc) begin
				i_q <= '0;
				cls_q <= cls_q + 2'd1;
			end
			strobe_q <= (hit && pend_q) || (ctrl.flush && pend_q);
			last_q <= ctrl.flush && pend_q;
			if (hit) begin
				pend_q <= 1'b1;
			end
			if (ctrl.flush) begin
				pend_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (run_start) begin
			cur_q <= node_addr;
		end
		if (ctrl.ld_link) begin
			cur_q <= node_rd[NW-1:llp_pkg::VALUE_W];
		end
		if (ctrl.node_rd_vis) begin
			a_q <= vis_rd;
		end
		if (hit) begin
			pend_addr_q <= a_q;
			pend_value_q <= rd_value;
			out_link_q <= 7'(a_q);
		end
		if (ctrl.flush) begin
			out_link_q <= llp_pkg::LINK_NULL;
		end
		if (hit || ctrl.flush) begin
			out_addr_q <= 6'(pend_addr_q);
			out_value_q <= pend_value_q;
		end
	end

	assign out_strobe = strobe_q;
	assign out_addr   = out_addr_q;
	assign out_value  = out_value_q;
	assign out_link   = out_link_q;
	assign last       = last_q;

endmodule

// ===== rtl/linked_list_three_way_partition.sv =====
`timescale 1ns / 1ps
// linked list three-way partition
// commands: start is taken at a clock edge with busy low
//   req_type 0 loads one node (node_value, link_addr) at node_addr;
//     busy stays low, addresses outside the table are dropped
//   req_type 1 walks the list from head node_addr (at most NODE_COUNT nodes,
//     a negative or out-of-table link ends it) and then emits the visited
//     nodes in order: negative values, then 0..threshold, then the rest
// results: one beat per node on out_addr/out_value/out_link/last, marked by
//   out_strobe for exactly one cycle; out_link names the next beat's node,
//   -1 with last high on the final beat; an empty list gives no beats
// the receiver cannot stall: beats are taken as they appear
// for each node the walk reads the node table, then follows the link, and
//   each of the three class scans then reads the visit list, reads the node
//   and classifies it, all through single-read rams
// control runs from a small microprogram; busy is high outside its idle step
// configuration: cfg_valid/cfg_ready write the threshold, ready always high
// reset: threshold 0, sequencer idle, no beat pending; node table is
//   undefined until loaded
module linked_list_three_way_partition #(
	parameter int NODE_COUNT = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	// command channel
	input  logic               start,
	output logic               busy,
	input  logic               req_type,
	input  logic signed [6:0]  node_addr,
	input  logic signed [31:0] node_value,
	input  logic signed [6:0]  link_addr,
	// threshold write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [30:0]        cfg_data,
	// result beats
	output logic               out_strobe,
	output logic [5:0]         out_addr,
	output logic signed [31:0] out_value,
	output logic signed [6:0]  out_link,
	output logic               last
);

	llp_pkg::ctrl_t   ctrl;
	llp_pkg::status_t status;

	// step counter, microcode rom and jump logic
	llp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	// node table, visit list, walk and scan counters, result register
	llp_dp #(.NODE_COUNT(NODE_COUNT)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.status     (status),
		.start      (start),
		.req_type   (req_type),
		.node_addr  (node_addr),
		.node_value (node_value),
		.link_addr  (link_addr),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.out_strobe (out_strobe),
		.out_addr   (out_addr),
		.out_value  (out_value),
		.out_link   (out_link),
		.last       (last)
	);

	assign busy      = !ctrl.accept;
	assign cfg_ready = 1'b1;

endmodule

// ===== rtl/llp_chk.sv =====
`timescale 1ns / 1ps
module llp_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              req_type,
	input logic              out_strobe,
	input logic signed [6:0] out_link,
	input logic              last
);

	// last only on a beat
	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> out_strobe)
		else $error("last without strobe");

	// final beat carries a null link
	a_last_null: assert property (@(posedge clk) disable iff (!arst_n)
		(out_strobe && last) |-> (out_link == 7'h7F))
		else $error("final beat link not null");

	// inner beats link to a real node
	a_inner_link: assert property (@(posedge clk) disable iff (!arst_n)
		(out_strobe && !last) |-> !out_link[6])
		else $error("inner beat link null");

	// a load finishes in its own cycle
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !req_type) |=> !busy)
		else $error("load left block busy");

	// a run holds the block busy afterwards
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type) |=> busy)
		else $error("run did not start");

endmodule

bind linked_list_three_way_partition llp_chk u_chk (.*);

// ===== sim/llp_partition_checker.sv =====
`timescale 1ns / 1ps
package llp_tb_pkg;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_RUN  = 1'b1;

endpackage

module llp_partition_checker #(
	parameter int NODE_COUNT = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               req_type,
	input  logic signed [6:0]  node_addr,
	input  logic signed [31:0] node_value,
	input  logic signed [6:0]  link_addr,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [30:0]        cfg_data,
	input  logic               out_strobe,
	input  logic [5:0]         out_addr,
	input  logic signed [31:0] out_value,
	input  logic signed [6:0]  out_link,
	input  logic               last,
	output int                 errors,
	output int                 beats_due,
	output int                 beats_seen,
	output int                 walks_seen,
	output int                 loads_seen
);

	typedef struct packed {
		logic [llp_pkg::ADDR_W-1:0]         addr;
		logic signed [llp_pkg::VALUE_W-1:0] value;
		logic signed [llp_pkg::LINK_W-1:0]  link;
		logic                               fin;
	} node_beat_t;

	logic signed [llp_pkg::VALUE_W-1:0] value_tbl [NODE_COUNT];
	logic signed [llp_pkg::LINK_W-1:0]  link_tbl  [NODE_COUNT];
	logic [llp_pkg::THR_W-1:0]          thr_m;
	node_beat_t                         partition_q [$];

	function automatic logic [1:0] value_class(
			input logic signed [llp_pkg::VALUE_W-1:0] v);
		if (v < 0)
			return llp_pkg::CLS_NEG;
		if ({1'b0, v[30:0]} <= {1'b0, thr_m})
			return llp_pkg::CLS_MID;
		return llp_pkg::CLS_HIGH;
	endfunction

	// walk from head, then queue the visited nodes as a stable three-way split
	function automatic void predict_partition(
			input logic signed [llp_pkg::LINK_W-1:0] head);
		logic [llp_pkg::ADDR_W-1:0]        walk [NODE_COUNT];
		node_beat_t                        run_beats [NODE_COUNT];
		logic signed [llp_pkg::LINK_W-1:0] cur;
		int                                n;
		int                                k;
		n = 0;
		k = 0;
		cur = head;
		while (cur >= 0 && cur < NODE_COUNT && n < NODE_COUNT) begin
			walk[n] = cur[llp_pkg::ADDR_W-1:0];
			n++;
			cur = link_tbl[cur[llp_pkg::ADDR_W-1:0]];
		end
		for (int c = llp_pkg::CLS_NEG; c <= llp_pkg::CLS_HIGH; c++) begin
			for (int i = 0; i < n; i++) begin
				if (value_class(value_tbl[walk[i]]) == 2'(c)) begin
					if (k > 0)
						run_beats[k-1].link = {1'b0, walk[i]};
					run_beats[k] = '{addr: walk[i], value: value_tbl[walk[i]],
						link: llp_pkg::LINK_NULL, fin: 1'b0};
					k++;
				end
			end
		end
		if (k > 0)
			run_beats[k-1].fin = 1'b1;
		for (int i = 0; i < k; i++)
			partition_q = {partition_q, run_beats[i]};
	endfunction

	always @(posedge clk) begin
		node_beat_t want;
		if (!arst_n) begin
			thr_m = '0;
			partition_q.delete();
			errors = 0;
			beats_seen = 0;
			walks_seen = 0;
			loads_seen = 0;
		end else begin
			if (out_strobe) begin
				beats_seen++;
				if (partition_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat addr %0d value %0d link %0d last %0b",
						$time, out_addr, out_value, out_link, last);
				end else begin
					want = partition_q.pop_front();
					if (out_addr !== want.addr) begin
						errors++;
						$display("%0t: out_addr expected %0d actual %0d",
							$time, want.addr, out_addr);
					end
					if (out_value !== want.value) begin
						errors++;
						$display("%0t: out_value expected %0d actual %0d",
							$time, want.value, out_value);
					end
					if (out_link !== want.link) begin
						errors++;
						$display("%0t: out_link expected %0d actual %0d",
							$time, want.link, out_link);
					end
					if (last !== want.fin) begin
						errors++;
						$display("%0t: last expected %0b actual %0b",
							$time, want.fin, last);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				thr_m = cfg_data;
			if (start && !busy) begin
				if (req_type == llp_tb_pkg::REQ_LOAD) begin
					if (node_addr >= 0 && node_addr < NODE_COUNT) begin
						value_tbl[node_addr[llp_pkg::ADDR_W-1:0]] = node_value;
						link_tbl[node_addr[llp_pkg::ADDR_W-1:0]] = link_addr;
						loads_seen++;
					end
				end else begin
					walks_seen++;
					predict_partition(node_addr);
				end
			end
		end
		beats_due = partition_q.size();
	end

endmodule

// ===== sim/tb_linked_list_three_way_partition.sv =====
`timescale 1ns / 1ps
module tb_linked_list_three_way_partition;

	localparam int NODE_COUNT = 64;
	localparam int MAX_ITEMS  = 300;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               req_type = llp_tb_pkg::REQ_LOAD;
	logic signed [6:0]  node_addr = '0;
	logic signed [31:0] node_value = '0;
	logic signed [6:0]  link_addr = '0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [30:0]        cfg_data = '0;
	logic               out_strobe;
	logic [5:0]         out_addr;
	logic signed [31:0] out_value;
	logic signed [6:0]  out_link;
	logic               last;

	int errors;
	int beats_due;
	int beats_seen;
	int walks_seen;
	int loads_seen;

	// stimulus-side view of the node table: which entries hold a node.
	// every load into the table links only to a loaded entry, to itself or to a
	// negative address, so no walk from a loaded head ever touches an empty entry
	bit                        loaded [NODE_COUNT];
	logic [llp_pkg::THR_W-1:0] thr_now;
	int                        items;
	int                        cfg_writes;
	bit                        calm;     // phase with no gaps between commands

	linked_list_three_way_partition #(
		.NODE_COUNT(NODE_COUNT)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req_type  (req_type),
		.node_addr (node_addr),
		.node_value(node_value),
		.link_addr (link_addr),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.out_strobe(out_strobe),
		.out_addr  (out_addr),
		.out_value (out_value),
		.out_link  (out_link),
		.last      (last)
	);

	llp_partition_checker #(
		.NODE_COUNT(NODE_COUNT)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req_type  (req_type),
		.node_addr (node_addr),
		.node_value(node_value),
		.link_addr (link_addr),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.out_strobe(out_strobe),
		.out_addr  (out_addr),
		.out_value (out_value),
		.out_link  (out_link),
		.last      (last),
		.errors    (errors),
		.beats_due (beats_due),
		.beats_seen(beats_seen),
		.walks_seen(walks_seen),
		.loads_seen(loads_seen)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// watchdog: the slowest legal run (every walk emitting 64 beats) is far
	// below this
	initial begin
		#40_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// one command beat; start stays high across back-to-back beats so it is
	// never lowered and raised in the same step
	task automatic issue(input logic kind, input logic signed [6:0] a,
			input logic signed [31:0] v, input logic signed [6:0] l);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= kind;
		node_addr <= a;
		node_value <= v;
		link_addr <= l;
		@(posedge clk);
		while (busy) @(posedge clk);
		// taken at this edge
		if (kind == llp_tb_pkg::REQ_RUN || a >= 0)
			items++;
		if (kind == llp_tb_pkg::REQ_LOAD && a >= 0)
			loaded[a[5:0]] = 1'b1;
	endtask

	// drop start, then wait until the walk is over and every beat is in;
	// the extra wait covers an empty walk still winding down
	task automatic settle();
		start <= 1'b0;
		do @(negedge clk); while (busy || beats_due != 0);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_threshold(input logic [llp_pkg::THR_W-1:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		thr_now = v;
		cfg_writes++;
	endtask

	function automatic int pick_loaded();
		int r;
		do r = $urandom_range(0, NODE_COUNT - 1); while (!loaded[r]);
		return r;
	endfunction

	// values cluster on the class boundaries: zero, the threshold, the extremes
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'($urandom());
			1: return 32'($urandom_range(0, 16)) - 32'd8;
			2: return {1'b0, thr_now} + 32'($urandom_range(0, 2)) - 32'd1;
			3: return 32'h8000_0000 + 32'($urandom_range(0, 3));
			4: return 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
			default: return 32'd0 - 32'($urandom_range(1, 1000));
		endcase
	endfunction

	// a negative link ends the list; mostly the null link
	function automatic logic signed [6:0] pick_end();
		if ($urandom_range(0, 2) == 0)
			return 7'($urandom_range(64, 126));
		return llp_pkg::LINK_NULL;
	endfunction

	function automatic logic signed [6:0] pick_link(input int a);
		int r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return pick_end();
		if (r == 3)
			return 7'(a);
		return 7'(pick_loaded());
	endfunction

	initial begin
		int perm [NODE_COUNT];
		int len;
		int j;
		int tmp;
		int a;
		int pick;
		items = 0;
		cfg_writes = 0;
		thr_now = '0;
		calm = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: chain 0 -> 1 -> 2 -> 63 holding min, zero, max and -1,
		// built tail first so every link to a node names a loaded node
		set_threshold('0);
		issue(llp_tb_pkg::REQ_LOAD, 7'sd63, -32'sd1, llp_pkg::LINK_NULL);
		issue(llp_tb_pkg::REQ_LOAD, 7'sd2, 32'sh7FFF_FFFF, 7'sd63);
		issue(llp_tb_pkg::REQ_LOAD, 7'sd1, 32'sd0, 7'sd2);
		issue(llp_tb_pkg::REQ_LOAD, 7'sd0, 32'sh8000_0000, 7'sd1);
		// single node whose link is the most negative address
		issue(llp_tb_pkg::REQ_LOAD, 7'sd3, 32'sd1, 7'sh40);
		// loads to negative addresses are dropped
		issue(llp_tb_pkg::REQ_LOAD, llp_pkg::LINK_NULL, 32'($urandom()), 7'sd0);
		issue(llp_tb_pkg::REQ_LOAD, 7'sh40, 32'sh5555_AAAA, 7'sd63);
		issue(llp_tb_pkg::REQ_RUN, 7'sd0, 32'($urandom()), 7'($urandom()));
		issue(llp_tb_pkg::REQ_RUN, 7'sd3, 32'($urandom()), 7'($urandom()));
		// null and negative heads give no beats
		issue(llp_tb_pkg::REQ_RUN, llp_pkg::LINK_NULL, 32'($urandom()), 7'($urandom()));
		issue(llp_tb_pkg::REQ_RUN, 7'sh40, 32'($urandom()), 7'($urandom()));
		// self loop: walk stops at the node cap, one beat per visit
		issue(llp_tb_pkg::REQ_LOAD, 7'sd5, 32'sd7, 7'sd5);
		issue(llp_tb_pkg::REQ_RUN, 7'sd5, 32'($urandom()), 7'($urandom()));
		// close the chain into a ring and enter it at two points
		issue(llp_tb_pkg::REQ_LOAD, 7'sd63, -32'sd1, 7'sd0);
		issue(llp_tb_pkg::REQ_RUN, 7'sd0, 32'($urandom()), 7'($urandom()));
		issue(llp_tb_pkg::REQ_RUN, 7'sd2, 32'($urandom()), 7'($urandom()));
		set_threshold(31'h7FFF_FFFF);
		issue(llp_tb_pkg::REQ_RUN, 7'sd0, 32'($urandom()), 7'($urandom()));
		set_threshold(31'd1);
		issue(llp_tb_pkg::REQ_RUN, 7'sd3, 32'($urandom()), 7'($urandom()));
		issue(llp_tb_pkg::REQ_RUN, 7'sd1, 32'($urandom()), 7'($urandom()));

		// random phases, mostly freshly built lists that are then walked
		while (items < MAX_ITEMS) begin
			calm = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 19);
			if (pick < 12) begin
				// mostly short lists, now and then a long one
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, NODE_COUNT)
					: $urandom_range(1, 8);
				for (int i = 0; i < NODE_COUNT; i++)
					perm[i] = i;
				for (int i = NODE_COUNT - 1; i > 0; i--) begin
					j = $urandom_range(0, i);
					tmp = perm[i];
					perm[i] = perm[j];
					perm[j] = tmp;
				end
				issue(llp_tb_pkg::REQ_LOAD, 7'(perm[len-1]), pick_value(), pick_end());
				for (int i = len - 2; i >= 0; i--)
					issue(llp_tb_pkg::REQ_LOAD, 7'(perm[i]), pick_value(),
						7'(perm[i+1]));
				// sometimes bend the tail back into the list
				if ($urandom_range(0, 3) == 0)
					issue(llp_tb_pkg::REQ_LOAD, 7'(perm[len-1]), pick_value(),
						7'(perm[$urandom_range(0, len - 1)]));
				if ($urandom_range(0, 5) == 0)
					issue(llp_tb_pkg::REQ_LOAD, 7'($urandom_range(64, 127)),
						pick_value(), pick_end());
				// usually from the head, sometimes from the middle
				a = ($urandom_range(0, 4) == 0) ? perm[$urandom_range(0, len - 1)] : perm[0];
				issue(llp_tb_pkg::REQ_RUN, 7'(a), 32'($urandom()), 7'($urandom()));
			end else if (pick < 16) begin
				// scattered loads over the table, then a walk from any loaded node
				repeat ($urandom_range(1, 6)) begin
					if ($urandom_range(0, 7) == 0) begin
						issue(llp_tb_pkg::REQ_LOAD, 7'($urandom_range(64, 127)),
							pick_value(), 7'($urandom()));
					end else begin
						a = $urandom_range(0, NODE_COUNT - 1);
						issue(llp_tb_pkg::REQ_LOAD, 7'(a), pick_value(), pick_link(a));
					end
				end
				issue(llp_tb_pkg::REQ_RUN, 7'(pick_loaded()), 32'($urandom()),
					7'($urandom()));
			end else if (pick < 19) begin
				if ($urandom_range(0, 3) == 0)
					issue(llp_tb_pkg::REQ_RUN, 7'($urandom_range(64, 127)),
						32'($urandom()), 7'($urandom()));
				else
					issue(llp_tb_pkg::REQ_RUN, 7'(pick_loaded()), 32'($urandom()),
						7'($urandom()));
			end else begin
				case ($urandom_range(0, 3))
					0: set_threshold('0);
					1: set_threshold(31'h7FFF_FFFF);
					2: set_threshold(31'($urandom()));
					default: set_threshold(31'($urandom_range(0, 16)));
				endcase
			end
		end

		settle();
		repeat (40) @(posedge clk);
		@(negedge clk);
		$display("covered %0d node loads and %0d walks giving %0d result beats",
			loads_seen, walks_seen, beats_seen);
		$display("across %0d threshold settings including both extremes", cfg_writes);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/llp_pkg.sv
rtl/llp_ram.sv
rtl/llp_seq.sv
rtl/llp_dp.sv
rtl/linked_list_three_way_partition.sv
rtl/llp_chk.sv
sim/llp_partition_checker.sv
sim/tb_linked_list_three_way_partition.sv
